/* design/glmm_pkg.sv */
// ----------------------------------------------------------------------------
// Grid local minimum map: shared package
// Types and constants used by the front end, the job queue and the back end.
// ----------------------------------------------------------------------------
package glmm_pkg;

    // Default sizes handed down from the top level.
    localparam int MAX_SIDE_DEFAULT    = 256;
    localparam int VALUE_WIDTH_DEFAULT = 16;

    // Side length register.
    localparam int                     GRID_SIZE_W     = 9;
    localparam logic [GRID_SIZE_W-1:0] GRID_SIZE_RESET = 9'd256;

    // Width of the reported coordinates.
    localparam int COORD_OUT_W = 8;

    // Entries in the queue between front end and back end.
    localparam int QUEUE_DEPTH = 4;

    // Row store selector: row r lives in store r mod 3.
    typedef logic [1:0] slot_t;
    localparam slot_t SLOT_0 = 2'd0;
    localparam slot_t SLOT_1 = 2'd1;
    localparam slot_t SLOT_2 = 2'd2;

    // Classification of one grid cell, worked out by the front end.
    typedef struct packed {
        slot_t slot;       // store that holds the cell's row
        logic  row_ge1;    // row 1 or later
        logic  row_ge2;    // row 2 or later
        logic  col_ge1;    // column 1 or later
        logic  col_ge2;    // column 2 or later
        logic  has_right;  // not in the last column
        logic  last_row;   // in the last row of the grid
        logic  last_col;   // in the last column of the grid
    } job_flags_t;

    localparam int JOB_FLAGS_W = $bits(job_flags_t);

endpackage

/* design/glmm_row_store.sv */
// ----------------------------------------------------------------------------
// Grid local minimum map: row store
// One grid row of values, one write port and two registered read ports.
// ----------------------------------------------------------------------------
module glmm_row_store #(
    parameter int  DEPTH  = glmm_pkg::MAX_SIDE_DEFAULT,
    parameter int  DATA_W = glmm_pkg::VALUE_WIDTH_DEFAULT,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr_a,
    input  logic [ADDR_W-1:0] rd_addr_b,
    output logic [DATA_W-1:0] rd_data_a,
    output logic [DATA_W-1:0] rd_data_b
);

    logic [DATA_W-1:0] row_mem [DEPTH];
    logic [DATA_W-1:0] rd_data_a_reg;
    logic [DATA_W-1:0] rd_data_b_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            row_mem[wr_addr] <= wr_data;
        end
    end

    // Two read ports with registered data.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_a_reg <= row_mem[rd_addr_a];
            rd_data_b_reg <= row_mem[rd_addr_b];
        end
    end

    assign rd_data_a = rd_data_a_reg;
    assign rd_data_b = rd_data_b_reg;

endmodule

/* design/glmm_job_queue.sv */
// ----------------------------------------------------------------------------
// Grid local minimum map: job queue
// Short first-in first-out queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module glmm_job_queue #(
    parameter int DATA_W = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  logic [DATA_W-1:0] push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output logic [DATA_W-1:0] pop_data
);
    import glmm_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [DATA_W-1:0] entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              push_fire;
    logic              pop_fire;

    // Handshake status.
    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_fire)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 :
                          wr_ptr_reg + PTR_W'(1);
        end
        if (pop_fire)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 :
                          rd_ptr_reg + PTR_W'(1);
        end
        if (push_fire && !pop_fire)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop_fire && !push_fire)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* design/glmm_front.sv */
// ----------------------------------------------------------------------------
// Grid local minimum map: front end
// Holds the side length register and the row and column counters, and tags
// each accepted cell with its position and border classification.
// ----------------------------------------------------------------------------
module glmm_front #(
    parameter int  MAX_SIDE    = glmm_pkg::MAX_SIDE_DEFAULT,
    parameter int  VALUE_WIDTH = glmm_pkg::VALUE_WIDTH_DEFAULT,
    localparam int COORD_W     = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [glmm_pkg::GRID_SIZE_W-1:0]   cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [VALUE_WIDTH-1:0]      cell_value,
    output logic                               push_valid,
    input  logic                               push_ready,
    output logic [VALUE_WIDTH-1:0]             push_value,
    output logic [COORD_W-1:0]                 push_row,
    output logic [COORD_W-1:0]                 push_col,
    output glmm_pkg::job_flags_t               push_flags
);
    import glmm_pkg::*;

    localparam int SIDE_W = $clog2(MAX_SIDE + 1);
    localparam int CMP_W  = (SIDE_W > GRID_SIZE_W) ? SIDE_W : GRID_SIZE_W;

    logic [GRID_SIZE_W-1:0] grid_size_reg;
    logic [GRID_SIZE_W-1:0] grid_size_next;
    logic [COORD_W-1:0]     row_reg;
    logic [COORD_W-1:0]     row_next;
    logic [COORD_W-1:0]     col_reg;
    logic [COORD_W-1:0]     col_next;
    slot_t                  slot_reg;
    slot_t                  slot_next;
    logic [CMP_W-1:0]       size_ext;
    logic [CMP_W-1:0]       side;
    logic [COORD_W-1:0]     last_idx;
    logic                   at_last_col;
    logic                   at_last_row;
    logic                   cfg_fire;
    logic                   push_fire;

    // The register port never stalls; cells pass straight on to the queue.
    assign cfg_ready  = 1'b1;
    assign cfg_fire   = cfg_valid && cfg_ready;
    assign push_valid = in_valid;
    assign in_ready   = push_ready;
    assign push_fire  = push_valid && push_ready;
    assign push_value = cell_value;

    // Effective side length: zero acts as one, oversize values saturate.
    always_comb
    begin
        size_ext = CMP_W'(grid_size_reg);
        if (size_ext == '0)
        begin
            side = CMP_W'(1);
        end
        else if (size_ext > CMP_W'(MAX_SIDE))
        begin
            side = CMP_W'(MAX_SIDE);
        end
        else
        begin
            side = size_ext;
        end
    end

    assign last_idx    = COORD_W'(side - CMP_W'(1));
    assign at_last_col = (col_reg == last_idx);
    assign at_last_row = (row_reg == last_idx);

    // Position and border classification of the cell being accepted.
    always_comb
    begin
        push_row             = row_reg;
        push_col             = col_reg;
        push_flags.slot      = slot_reg;
        push_flags.row_ge1   = (row_reg != '0);
        push_flags.row_ge2   = (row_reg > COORD_W'(1));
        push_flags.col_ge1   = (col_reg != '0);
        push_flags.col_ge2   = (col_reg > COORD_W'(1));
        push_flags.has_right = !at_last_col;
        push_flags.last_row  = at_last_row;
        push_flags.last_col  = at_last_col;
    end

    // Raster counters; a register write restarts the grid at the origin.
    always_comb
    begin
        grid_size_next = grid_size_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        slot_next      = slot_reg;
        if (cfg_fire)
        begin
            grid_size_next = cfg_data;
            row_next       = '0;
            col_next       = '0;
            slot_next      = SLOT_0;
        end
        else if (push_fire)
        begin
            if (at_last_col)
            begin
                col_next = '0;
                if (at_last_row)
                begin
                    row_next  = '0;
                    slot_next = SLOT_0;
                end
                else
                begin
                    row_next = row_reg + COORD_W'(1);
                    case (slot_reg)
                        SLOT_0:  slot_next = SLOT_1;
                        SLOT_1:  slot_next = SLOT_2;
                        default: slot_next = SLOT_0;
                    endcase
                end
            end
            else
            begin
                col_next = col_reg + COORD_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_size_reg <= GRID_SIZE_RESET;
            row_reg       <= '0;
            col_reg       <= '0;
            slot_reg      <= SLOT_0;
        end
        else
        begin
            grid_size_reg <= grid_size_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            slot_reg      <= slot_next;
        end
    end

endmodule

/* design/glmm_back.sv */
// ----------------------------------------------------------------------------
// Grid local minimum map: back end
// Writes each cell into its row store, fetches the neighbors from the two
// earlier rows, compares, and hands out up to three results per cell.
// ----------------------------------------------------------------------------
module glmm_back #(
    parameter int  MAX_SIDE    = glmm_pkg::MAX_SIDE_DEFAULT,
    parameter int  VALUE_WIDTH = glmm_pkg::VALUE_WIDTH_DEFAULT,
    localparam int COORD_W     = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               q_valid,
    output logic                               q_ready,
    input  logic [VALUE_WIDTH-1:0]             q_value,
    input  logic [COORD_W-1:0]                 q_row,
    input  logic [COORD_W-1:0]                 q_col,
    input  glmm_pkg::job_flags_t               q_flags,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [glmm_pkg::COORD_OUT_W-1:0]   cell_row,
    output logic [glmm_pkg::COORD_OUT_W-1:0]   cell_col,
    output logic                               is_minimum,
    output logic                               last_cell
);
    import glmm_pkg::*;

    // Pending result bits: cell above, cell to the left, final cell.
    localparam int PEND_UP   = 0;
    localparam int PEND_LEFT = 1;
    localparam int PEND_LAST = 2;

    logic                          pop;
    logic [COORD_W-1:0]            rd_addr_right;
    logic [VALUE_WIDTH-1:0]        rd_a0;
    logic [VALUE_WIDTH-1:0]        rd_b0;
    logic [VALUE_WIDTH-1:0]        rd_a1;
    logic [VALUE_WIDTH-1:0]        rd_b1;
    logic [VALUE_WIDTH-1:0]        rd_a2;
    logic [VALUE_WIDTH-1:0]        rd_b2;

    logic [COORD_W-1:0]            b_row_reg;
    logic [COORD_W-1:0]            b_col_reg;
    logic signed [VALUE_WIDTH-1:0] b_value_reg;
    job_flags_t                    b_flags_reg;
    logic [2:0]                    pend_reg;
    logic [2:0]                    pend_next;
    logic signed [VALUE_WIDTH-1:0] prev_ctr_reg;
    logic signed [VALUE_WIDTH-1:0] cur1_reg;
    logic signed [VALUE_WIDTH-1:0] cur2_reg;

    logic signed [VALUE_WIDTH-1:0] center;
    logic signed [VALUE_WIDTH-1:0] above;
    logic signed [VALUE_WIDTH-1:0] right;
    logic                          up_min;
    logic                          left_min;
    logic                          last_min;
    logic [2:0]                    sel;
    logic [2:0]                    pend_after;
    logic [2:0]                    new_pend;
    logic                          out_free;
    logic                          fire;
    logic [COORD_W-1:0]            row_above;
    logic [COORD_W-1:0]            col_before;

    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [COORD_OUT_W-1:0]        out_row_reg;
    logic [COORD_OUT_W-1:0]        out_row_next;
    logic [COORD_OUT_W-1:0]        out_col_reg;
    logic [COORD_OUT_W-1:0]        out_col_next;
    logic                          out_min_reg;
    logic                          out_min_next;
    logic                          out_last_reg;
    logic                          out_last_next;

    // Three row stores; each cell is written into the store of its row and
    // the two other stores are read at the cell's column and, if any, the next one.
    assign rd_addr_right = q_flags.has_right ? (q_col + COORD_W'(1)) : q_col;

    glmm_row_store #(
        .DEPTH  (MAX_SIDE),
        .DATA_W (VALUE_WIDTH)
    ) u_store0 (
        .clk       (clk),
        .wr_en     (pop && (q_flags.slot == SLOT_0)),
        .wr_addr   (q_col),
        .wr_data   (q_value),
        .rd_en     (pop),
        .rd_addr_a (q_col),
        .rd_addr_b (rd_addr_right),
        .rd_data_a (rd_a0),
        .rd_data_b (rd_b0)
    );

    glmm_row_store #(
        .DEPTH  (MAX_SIDE),
        .DATA_W (VALUE_WIDTH)
    ) u_store1 (
        .clk       (clk),
        .wr_en     (pop && (q_flags.slot == SLOT_1)),
        .wr_addr   (q_col),
        .wr_data   (q_value),
        .rd_en     (pop),
        .rd_addr_a (q_col),
        .rd_addr_b (rd_addr_right),
        .rd_data_a (rd_a1),
        .rd_data_b (rd_b1)
    );

    glmm_row_store #(
        .DEPTH  (MAX_SIDE),
        .DATA_W (VALUE_WIDTH)
    ) u_store2 (
        .clk       (clk),
        .wr_en     (pop && (q_flags.slot == SLOT_2)),
        .wr_addr   (q_col),
        .wr_data   (q_value),
        .rd_en     (pop),
        .rd_addr_a (q_col),
        .rd_addr_b (rd_addr_right),
        .rd_data_a (rd_a2),
        .rd_data_b (rd_b2)
    );

    // Pick the previous row (center, right) and the row before it (above).
    always_comb
    begin
        case (b_flags_reg.slot)
            SLOT_0:
            begin
                center = rd_a2;
                right  = rd_b2;
                above  = rd_a1;
            end
            SLOT_1:
            begin
                center = rd_a0;
                right  = rd_b0;
                above  = rd_a2;
            end
            default:
            begin
                center = rd_a1;
                right  = rd_b1;
                above  = rd_a0;
            end
        endcase
    end

    // Neighbor compares for the three possible results of the current cell.
    // Cell above: its lower neighbor is the current value.
    assign up_min = !(b_flags_reg.row_ge2 && (above < center)) &&
                    !(b_value_reg < center) &&
                    !(b_flags_reg.col_ge1 && (prev_ctr_reg < center)) &&
                    !(b_flags_reg.has_right && (right < center));

    // Last row, cell to the left: its right neighbor is the current value.
    assign left_min = !(b_flags_reg.row_ge1 && (prev_ctr_reg < cur1_reg)) &&
                      !(b_flags_reg.col_ge2 && (cur2_reg < cur1_reg)) &&
                      !(b_value_reg < cur1_reg);

    // Final cell of the grid: only the upper and left neighbors exist.
    assign last_min = !(b_flags_reg.row_ge1 && (center < b_value_reg)) &&
                      !(b_flags_reg.col_ge1 && (cur1_reg < b_value_reg));

    assign row_above  = b_row_reg - COORD_W'(1);
    assign col_before = b_col_reg - COORD_W'(1);

    // Result sequencing: oldest pending result first, one per transfer.
    always_comb
    begin
        sel = '0;
        if (pend_reg[PEND_UP])
        begin
            sel[PEND_UP] = 1'b1;
        end
        else if (pend_reg[PEND_LEFT])
        begin
            sel[PEND_LEFT] = 1'b1;
        end
        else if (pend_reg[PEND_LAST])
        begin
            sel[PEND_LAST] = 1'b1;
        end
    end

    assign out_free   = !out_valid_reg || out_ready;
    assign fire       = out_free && (pend_reg != '0);
    assign pend_after = fire ? (pend_reg & ~sel) : pend_reg;
    assign q_ready    = (pend_after == '0);
    assign pop        = q_valid && q_ready;

    always_comb
    begin
        new_pend            = '0;
        new_pend[PEND_UP]   = q_flags.row_ge1;
        new_pend[PEND_LEFT] = q_flags.last_row && q_flags.col_ge1;
        new_pend[PEND_LAST] = q_flags.last_row && q_flags.last_col;
        pend_next           = pop ? new_pend : pend_after;
    end

    // Output register contents.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_row_next   = out_row_reg;
        out_col_next   = out_col_reg;
        out_min_next   = out_min_reg;
        out_last_next  = out_last_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
            if (sel[PEND_UP])
            begin
                out_row_next  = COORD_OUT_W'(row_above);
                out_col_next  = COORD_OUT_W'(b_col_reg);
                out_min_next  = up_min;
                out_last_next = 1'b0;
            end
            else if (sel[PEND_LEFT])
            begin
                out_row_next  = COORD_OUT_W'(b_row_reg);
                out_col_next  = COORD_OUT_W'(col_before);
                out_min_next  = left_min;
                out_last_next = 1'b0;
            end
            else
            begin
                out_row_next  = COORD_OUT_W'(b_row_reg);
                out_col_next  = COORD_OUT_W'(b_col_reg);
                out_min_next  = last_min;
                out_last_next = 1'b1;
            end
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working cell and the sliding window of earlier values. On each load the
    // outgoing cell's center and value shift into the left-hand taps.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            b_row_reg    <= q_row;
            b_col_reg    <= q_col;
            b_value_reg  <= q_value;
            b_flags_reg  <= q_flags;
            prev_ctr_reg <= center;
            cur1_reg     <= b_value_reg;
            cur2_reg     <= cur1_reg;
        end
        out_row_reg  <= out_row_next;
        out_col_reg  <= out_col_next;
        out_min_reg  <= out_min_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid  = out_valid_reg;
    assign cell_row   = out_row_reg;
    assign cell_col   = out_col_reg;
    assign is_minimum = out_min_reg;
    assign last_cell  = out_last_reg;

endmodule

/* design/grid_local_minimum_map_core.sv */
// ----------------------------------------------------------------------------
// Grid local minimum map core
// Path: a taken cell goes through the job queue and the back end's working
// registers to its output register. Throughput: one cell per cycle while the
// output is not stalled, set by the back end's single compare window; last-row
// cells past the first column yield two or three results, one per transfer.
// Reset: side length 256, next cell is the origin; row stores are not cleared.
// ----------------------------------------------------------------------------
module grid_local_minimum_map_core #(
    parameter int  MAX_SIDE    = glmm_pkg::MAX_SIDE_DEFAULT,
    parameter int  VALUE_WIDTH = glmm_pkg::VALUE_WIDTH_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [glmm_pkg::GRID_SIZE_W-1:0]   cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [VALUE_WIDTH-1:0]      cell_value,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [glmm_pkg::COORD_OUT_W-1:0]   cell_row,
    output logic [glmm_pkg::COORD_OUT_W-1:0]   cell_col,
    output logic                               is_minimum,
    output logic                               last_cell
);
    import glmm_pkg::*;

    localparam int COORD_W = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int JOB_W   = VALUE_WIDTH + 2 * COORD_W + JOB_FLAGS_W;

    logic                   push_valid;
    logic                   push_ready;
    logic [VALUE_WIDTH-1:0] push_value;
    logic [COORD_W-1:0]     push_row;
    logic [COORD_W-1:0]     push_col;
    job_flags_t             push_flags;
    logic [JOB_W-1:0]       push_data;
    logic                   q_valid;
    logic                   q_ready;
    logic [JOB_W-1:0]       q_data;
    logic [VALUE_WIDTH-1:0] q_value;
    logic [COORD_W-1:0]     q_row;
    logic [COORD_W-1:0]     q_col;
    job_flags_t             q_flags;

    // Front end: register, counters and cell classification.
    glmm_front #(
        .MAX_SIDE    (MAX_SIDE),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cell_value (cell_value),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_value (push_value),
        .push_row   (push_row),
        .push_col   (push_col),
        .push_flags (push_flags)
    );

    // Job queue between the two halves.
    assign push_data = {push_value, push_row, push_col, push_flags};

    glmm_job_queue #(
        .DATA_W (JOB_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_data)
    );

    assign {q_value, q_row, q_col, q_flags} = q_data;

    // Back end: row stores, neighbor compares and result output.
    glmm_back #(
        .MAX_SIDE    (MAX_SIDE),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_value    (q_value),
        .q_row      (q_row),
        .q_col      (q_col),
        .q_flags    (q_flags),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .cell_row   (cell_row),
        .cell_col   (cell_col),
        .is_minimum (is_minimum),
        .last_cell  (last_cell)
    );

endmodule
